// ===== hdl/dper_pkg.sv =====
// Shared types, register indexes and opcode decode for the display packet effect rewriter.
// No dependencies; used by dper_rewrite and the top level.
package dper_pkg;

   localparam int WORD_W = 32;
   localparam int CLUT_W = 16;

   // configuration register indexes
   localparam logic [1:0] CSR_EFFECT_MODE = 2'd0;
   localparam logic [1:0] CSR_EFFECT_WORD = 2'd1;
   localparam logic [1:0] CSR_CLUT_ID     = 2'd2;

   localparam logic [7:0]        OPCODE_MASK = 8'hFC;
   localparam logic [WORD_W-1:0] SEMI_MASK   = 32'h0200_0000;
   localparam logic [7:0]        ADD_NEUTRAL = 8'h80;
   localparam logic [8:0]        ADD_BIAS    = 9'h07F;

   typedef enum logic [2:0] {
      MODE_SEMI_ON   = 3'd0,
      MODE_SEMI_OFF  = 3'd1,
      MODE_CLUT_SWAP = 3'd2,
      MODE_FLAT_TINT = 3'd3,
      MODE_COLOUR_ADD = 3'd4
   } effect_mode_type;

   typedef struct packed {
      effect_mode_type   mode;
      logic [WORD_W-1:0] tint;
      logic [CLUT_W-1:0] clut;
   } dper_cfg_type;

   typedef struct packed {
      logic [3:0] pos;
      logic [3:0] len;
      logic [2:0] cc;
      logic       fault;
   } dper_state_type;

   typedef struct packed {
      logic       known;
      logic [3:0] len;
      logic [2:0] cc;
   } opcode_info_type;

   function automatic opcode_info_type decode_opcode(input logic [7:0] op);
      opcode_info_type info;
      info = '{known: 1'b1, len: 4'd0, cc: 3'd0};
      unique case (op)
         8'h20: info.len = 4'd5;
         8'h24: begin info.len = 4'd8;  info.cc = 3'd1; end
         8'h28: info.len = 4'd6;
         8'h2C: begin info.len = 4'd10; info.cc = 3'd1; end
         8'h30: info.len = 4'd7;
         8'h34: begin info.len = 4'd10; info.cc = 3'd3; end
         8'h38: info.len = 4'd9;
         8'h3C: begin info.len = 4'd13; info.cc = 3'd4; end
         default: info.known = 1'b0;
      endcase
      return info;
   endfunction

endpackage

// ===== hdl/dper_rewrite.sv =====
// Combinational packet word rewrite: position tracking, opcode decode and effects.
// Depends on dper_pkg.
module dper_rewrite
   import dper_pkg::*;
(
   input  dper_state_type    state,
   input  dper_cfg_type      cfg,
   input  logic [WORD_W-1:0] word,
   output dper_state_type    state_next,
   output logic [WORD_W-1:0] word_out
);

   opcode_info_type   info;
   dper_state_type    st;
   logic              colour_word;
   logic [4:0]        pos_inc;
   logic [WORD_W-1:0] added;
   logic [WORD_W-1:0] effected;

   assign info = decode_opcode(word[31:24] & OPCODE_MASK);

   // per-channel darken / identity / brighten with clamping; top byte untouched
   always_comb begin
      logic [7:0] t;
      logic [7:0] p;
      logic [8:0] sum;
      added = word;
      for (int ch = 0; ch < 3; ch++) begin
         t   = cfg.tint[ch*8 +: 8];
         p   = word[ch*8 +: 8];
         sum = {1'b0, p} + {1'b0, t};
         if (t < ADD_NEUTRAL) begin
            added[ch*8 +: 8] = (sum >= ADD_BIAS) ? 8'(sum - ADD_BIAS) : 8'd0;
         end else if (t > ADD_NEUTRAL) begin
            added[ch*8 +: 8] = sum[8] ? 8'hFF : sum[7:0];
         end
      end
   end

   always_comb begin
      st = state;
      if (!state.fault && state.pos == 4'd1) begin
         if (!info.known) begin
            st.fault = 1'b1;
         end else begin
            st.len = info.len;
            st.cc  = info.cc;
         end
      end
   end

   assign colour_word = (st.pos == 4'd1  && st.cc >= 3'd1) ||
                        (st.pos == 4'd4  && st.cc >= 3'd2) ||
                        (st.pos == 4'd7  && st.cc >= 3'd3) ||
                        (st.pos == 4'd10 && st.cc >= 3'd4);

   always_comb begin
      effected = word;
      unique case (cfg.mode)
         MODE_SEMI_ON:   if (st.pos == 4'd1) effected = word | SEMI_MASK;
         MODE_SEMI_OFF:  if (st.pos == 4'd1) effected = word & ~SEMI_MASK;
         MODE_CLUT_SWAP: if (st.pos == 4'd3) effected = {cfg.clut, word[15:0]};
         MODE_FLAT_TINT: begin
            if (colour_word) begin
               effected = (st.pos == 4'd1) ?
                  {word[31:24] | SEMI_MASK[31:24], cfg.tint[23:0]} : cfg.tint;
            end
         end
         MODE_COLOUR_ADD: if (colour_word) effected = added;
         default: effected = word;
      endcase
   end

   assign pos_inc = {1'b0, st.pos} + 5'd1;

   always_comb begin
      state_next = st;
      word_out   = word;
      if (!st.fault) begin
         if (st.pos != 4'd0 && st.cc != 3'd0) begin
            word_out = effected;
         end
         priority if (st.pos == 4'd0) begin
            state_next.pos = 4'd1;
         end else if (pos_inc >= {1'b0, st.len}) begin
            state_next.pos = 4'd0;
         end else begin
            state_next.pos = pos_inc[3:0];
         end
      end
   end

endmodule

// ===== hdl/display_packet_effect_rewriter_unit.sv =====
// Channel  Ports                       Payload
// request  req_tvalid/tready/tdata/last packet_word, span_end on tlast
// result   rsp_tvalid/tready/tdata/last/user out_word, out_end on tlast, bad_opcode on tuser
// config   csr_we/index/wdata           effect_mode, effect_word, clut_id
//
// One word per clock sustained while results are taken; a word passes through the
// input register, then the result register, with the rewrite logic between them.
// Reset is synchronous and clears valids, packet state and configuration.
// A stalled result holds; the input register still fills, and the request side
// stalls only when both registers are full.
// Depends on dper_pkg and dper_rewrite.
module display_packet_effect_rewriter_unit
   import dper_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [WORD_W-1:0] req_tdata,   // [31:0] packet_word
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [WORD_W-1:0] rsp_tdata,   // [31:0] out_word
   output logic              rsp_tlast,
   output logic              rsp_tuser,   // [0] bad_opcode
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [WORD_W-1:0] csr_wdata
);

   dper_cfg_type      cfg_ff, cfg_in;
   dper_state_type    state_ff, state_in, state_next;
   logic              in_valid_ff, in_valid_in;
   logic [WORD_W-1:0] in_word_ff;
   logic              in_end_ff;
   logic              out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] out_word_ff;
   logic              out_end_ff;
   logic              out_fault_ff;
   logic [WORD_W-1:0] word_new;
   logic              adv_out;
   logic              adv_in;

   assign adv_out    = !out_valid_ff || rsp_tready;
   assign adv_in     = !in_valid_ff || adv_out;
   assign req_tready = adv_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         if (csr_index == CSR_EFFECT_MODE) cfg_in.mode = effect_mode_type'(csr_wdata[2:0]);
         if (csr_index == CSR_EFFECT_WORD) cfg_in.tint = csr_wdata;
         if (csr_index == CSR_CLUT_ID)     cfg_in.clut = csr_wdata[CLUT_W-1:0];
      end
   end

   dper_rewrite u_rewrite (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .word       (in_word_ff),
      .state_next (state_next),
      .word_out   (word_new)
   );

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (in_valid_ff && adv_out) begin
         out_valid_in = 1'b1;
         // drop packet state after the last word of the span
         state_in = in_end_ff ? '0 : state_next;
      end
      in_valid_in = in_valid_ff && !adv_out;
      if (req_tvalid && adv_in) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{mode: MODE_SEMI_ON, tint: '0, clut: '0};
         state_ff     <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && adv_in) begin
         in_word_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
      if (in_valid_ff && adv_out) begin
         out_word_ff  <= word_new;
         out_end_ff   <= in_end_ff;
         out_fault_ff <= state_next.fault;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_word_ff;
   assign rsp_tlast  = out_end_ff;
   assign rsp_tuser  = out_fault_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for display_packet_effect_rewriter_unit: drives packet spans
// under every effect setting and checks each rewritten word against a local model.
// Depends on dper_pkg and the rewriter RTL.
module tb_top;
   import dper_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASES       = 16;
   localparam int PHASE_WORDS  = 34;
   localparam int OP_COUNT     = 8;
   localparam logic [1:0] CSR_SPARE = 2'd3;   // unmapped index, must be ignored

   // drawing opcodes with their stride and number of colour words, slot 7 first
   localparam logic [OP_COUNT-1:0][7:0] OP_CODE =
      {8'h3C, 8'h38, 8'h34, 8'h30, 8'h2C, 8'h28, 8'h24, 8'h20};
   localparam logic [OP_COUNT-1:0][3:0] OP_LEN =
      {4'd13, 4'd9, 4'd10, 4'd7, 4'd10, 4'd6, 4'd8, 4'd5};
   localparam logic [OP_COUNT-1:0][2:0] OP_COLOURS =
      {3'd4, 3'd0, 3'd3, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0};

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
   } span_word_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
      logic              bad;
   } rewritten_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [WORD_W-1:0] req_tdata = '0;
   logic              req_tlast = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [WORD_W-1:0] rsp_tdata;
   logic              rsp_tlast;
   logic              rsp_tuser;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [WORD_W-1:0] csr_wdata = '0;

   display_packet_effect_rewriter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   span_word_type words_to_send[$];
   rewritten_type rewrites_due[$];

   // register copies
   logic [2:0]        cfg_mode = MODE_SEMI_ON;
   logic [WORD_W-1:0] cfg_tint = '0;
   logic [CLUT_W-1:0] cfg_clut = '0;

   // packet tracking copies
   logic [3:0] word_pos   = '0;
   logic [3:0] pkt_len    = '0;
   logic [2:0] colour_cnt = '0;
   logic       fault_seen = 1'b0;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  queued_count = 0;
   int  rsp_count = 0;
   int  mismatches = 0;
   int  cycle_count = 0;
   int  bad_spans = 0;
   int  settings_count = 0;
   bit  req_fire = 1'b0;

   function automatic int op_slot(input logic [7:0] op);
      op_slot = -1;
      for (int s = 0; s < OP_COUNT; s++)
         if (OP_CODE[s] == op) op_slot = s;
   endfunction

   function automatic logic [WORD_W-1:0] add_colour(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] r;
      logic [9:0]        t;
      logic [9:0]        sum;
      r = w;
      for (int ch = 0; ch < 3; ch++) begin
         t   = {2'b00, cfg_tint[ch*8 +: 8]};
         sum = {2'b00, w[ch*8 +: 8]} + t;
         if (t < {2'b00, ADD_NEUTRAL})
            r[ch*8 +: 8] = (sum >= {1'b0, ADD_BIAS}) ? 8'(sum - {1'b0, ADD_BIAS}) : 8'h00;
         else if (t > {2'b00, ADD_NEUTRAL})
            r[ch*8 +: 8] = (sum > 10'd255) ? 8'hFF : sum[7:0];
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] apply_effect(input logic [3:0] pos,
                                                      input logic [WORD_W-1:0] w);
      logic tinted;
      tinted = (pos == 1 && colour_cnt >= 1) || (pos == 4 && colour_cnt >= 2) ||
               (pos == 7 && colour_cnt >= 3) || (pos == 10 && colour_cnt >= 4);
      case (cfg_mode)
         MODE_SEMI_ON:    return (pos == 1) ? (w | SEMI_MASK) : w;
         MODE_SEMI_OFF:   return (pos == 1) ? (w & ~SEMI_MASK) : w;
         MODE_CLUT_SWAP:  return (pos == 3) ? {cfg_clut, w[15:0]} : w;
         MODE_FLAT_TINT: begin
            if (!tinted) return w;
            if (pos == 1) return {w[31:24] | SEMI_MASK[31:24], cfg_tint[23:0]};
            return cfg_tint;
         end
         MODE_COLOUR_ADD: return tinted ? add_colour(w) : w;
         default:         return w;
      endcase
   endfunction

   function automatic rewritten_type rewrite_word(input span_word_type req);
      rewritten_type rsp;
      int            slot;
      rsp.word = req.word;
      if (!fault_seen) begin
         if (word_pos == 1) begin
            slot = op_slot(req.word[31:24] & OPCODE_MASK);
            if (slot < 0) begin
               fault_seen = 1'b1;
            end else begin
               pkt_len    = OP_LEN[slot];
               colour_cnt = OP_COLOURS[slot];
            end
         end
         if (!fault_seen) begin
            if (word_pos >= 1 && colour_cnt != 0) rsp.word = apply_effect(word_pos, req.word);
            if (word_pos == 0)
               word_pos = 4'd1;
            else if ({1'b0, word_pos} + 5'd1 >= {1'b0, pkt_len})
               word_pos = 4'd0;
            else
               word_pos = word_pos + 4'd1;
         end
      end
      rsp.last = req.last;
      rsp.bad  = fault_seen;
      // span end clears everything, even mid-packet
      if (req.last) begin
         if (fault_seen) bad_spans++;
         word_pos   = '0;
         pkt_len    = '0;
         colour_cnt = '0;
         fault_seen = 1'b0;
      end
      return rsp;
   endfunction

   function automatic void note_mismatch(input string what, input rewritten_type due,
                                         input rewritten_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch (%s) at cycle %0d: expected word %h last %b bad %b, %s%h%s%b%s%b",
                  what, cycle_count, due.word, due.last, due.bad,
                  "got word ", got.word, " last ", got.last, " bad ", got.bad);
   endfunction

   // driver: advance to the next request once the current one is taken
   always @(negedge clock) begin
      span_word_type nxt;
      if (!req_tvalid || req_fire) begin
         if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = words_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= nxt.word;
            req_tlast  <= nxt.last;
         end else begin
            req_tvalid <= 1'b0;
            req_tdata  <= $urandom;
            req_tlast  <= 1'(($urandom));
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // monitor: check results first, then record what the accepted request will produce
   always @(posedge clock) begin
      rewritten_type got;
      rewritten_type due;
      span_word_type req;
      cycle_count++;
      req_fire = req_tvalid && req_tready && !reset;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            got = '{word: rsp_tdata, last: rsp_tlast, bad: rsp_tuser};
            if (rewrites_due.size() == 0) begin
               note_mismatch("nothing pending", '0, got);
            end else begin
               due = rewrites_due.pop_front();
               if (got.word !== due.word || got.last !== due.last || got.bad !== due.bad)
                  note_mismatch("field", due, got);
            end
         end
         if (req_fire) begin
            req = '{word: req_tdata, last: req_tlast};
            rewrites_due.push_back(rewrite_word(req));
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d of %0d results seen",
               cycle_count, rsp_count, queued_count);
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'h7F;
         2: return 8'h80;
         3: return 8'hFF;
         4: return 8'h7E;
         5: return 8'h81;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [23:0] pick_colour();
      return {pick_byte(), pick_byte(), pick_byte()};
   endfunction

   function automatic logic [WORD_W-1:0] packet_word(input int slot, input int pos);
      logic [WORD_W-1:0] noise;
      noise = $urandom;
      if (pos == 1)
         return {OP_CODE[slot] | 8'(noise[25:24]), pick_colour()};
      if ((pos == 4 && OP_COLOURS[slot] >= 2) || (pos == 7 && OP_COLOURS[slot] >= 3) ||
          (pos == 10 && OP_COLOURS[slot] >= 4))
         return {noise[31:24], pick_colour()};
      return noise;
   endfunction

   task automatic push_word(input logic [WORD_W-1:0] w, input logic last);
      words_to_send.push_back('{word: w, last: last});
      queued_count++;
   endtask

   task automatic queue_packet(input int slot, input int cut, input bit ends_span);
      for (int i = 0; i < cut; i++)
         push_word(packet_word(slot, i), ends_span && i == cut - 1);
   endtask

   task automatic queue_span();
      int         packets;
      int         slot;
      int         cut;
      int         extra;
      logic [7:0] junk_op;
      packets = $urandom_range(1, 4);
      for (int p = 0; p < packets; p++) begin
         if ($urandom_range(0, 99) < 12) begin
            // bad opcode: everything passes until the span closes, so close it soon
            push_word($urandom, 1'b0);
            do junk_op = 8'($urandom_range(0, 255));
            while (op_slot(junk_op & OPCODE_MASK) >= 0);
            extra = $urandom_range(0, 3);
            push_word({junk_op, 24'($urandom)}, extra == 0);
            for (int i = 0; i < extra; i++) push_word($urandom, i == extra - 1);
            return;
         end
         slot = $urandom_range(0, OP_COUNT - 1);
         cut  = OP_LEN[slot];
         if (p == packets - 1 && $urandom_range(0, 9) == 0) cut = $urandom_range(1, cut - 1);
         queue_packet(slot, cut, p == packets - 1);
      end
   endtask

   task automatic drain();
      while (rsp_count < queued_count) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_settings(input logic [2:0] mode, input logic [WORD_W-1:0] tint,
                                input logic [CLUT_W-1:0] clut);
      logic [WORD_W-1:0] noise;
      noise = $urandom;
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_EFFECT_MODE;
      csr_wdata <= {noise[31:3], mode};
      @(negedge clock);
      csr_index <= CSR_EFFECT_WORD;
      csr_wdata <= tint;
      @(negedge clock);
      csr_index <= CSR_CLUT_ID;
      csr_wdata <= {noise[15:0], clut};
      @(negedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= ~noise;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_mode = mode;
      cfg_tint = tint;
      cfg_clut = clut;
      settings_count++;
   endtask

   initial begin
      logic [2:0]        mode;
      logic [WORD_W-1:0] tint;
      logic [CLUT_W-1:0] clut;
      int                target;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed spans under reset settings (semi on, zero tint and palette)
      send_idle_pct = 16;
      recv_idle_pct = 67;
      push_word(32'h0000_0000, 1'b0);
      push_word({OP_CODE[0], 24'h00_0000}, 1'b0);
      for (int i = 2; i < OP_LEN[0]; i++) push_word(packet_word(0, i), 1'b0);
      push_word(32'hFFFF_FFFF, 1'b0);
      for (int i = 1; i < OP_LEN[7]; i++) push_word(packet_word(7, i), 1'b0);
      push_word($urandom, 1'b0);
      push_word(32'hFFFF_FFFF, 1'b0);
      push_word(32'h0000_0000, 1'b1);
      queue_packet(1, 3, 1'b1);
      push_word($urandom, 1'b1);

      for (int k = 0; k < PHASES; k++) begin
         drain();
         if (k < 5) begin
            send_idle_pct = 16;
            recv_idle_pct = 67;
         end else if (k < 11) begin
            send_idle_pct = 67;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (k < 8)
            mode = k[2:0];
         else if (k % 2)
            mode = MODE_COLOUR_ADD;
         else
            mode = (k % 4 == 0) ? MODE_FLAT_TINT : MODE_CLUT_SWAP;
         case ((k / 2) % 4)
            0: tint = 32'h0000_0000;
            1: tint = 32'hFFFF_FFFF;
            2: tint = {8'($urandom), pick_colour()};
            default: tint = $urandom;
         endcase
         clut = (k == 2) ? 16'h0000 : (((k / 2) % 2) ? 16'hFFFF : 16'($urandom));
         load_settings(mode, tint, clut);
         target = queued_count + PHASE_WORDS;
         while (queued_count < target) queue_span();
      end

      drain();
      $display("%0d packet words rewritten over %0d register settings", queued_count,
               settings_count);
      $display("%0d spans carried a bad opcode; %0d results left unmatched",
               bad_spans, rewrites_due.size());
      if (mismatches == 0 && rewrites_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/dper_pkg.sv
hdl/dper_rewrite.sv
hdl/display_packet_effect_rewriter_unit.sv
tb/tb_top.sv
